/* src/urlpd_pkg.sv */
// Shared definitions for the URL path percent decoder.
// Character codes, state codes and the hex digit decoder.
// No dependencies.
package urlpd_pkg;

  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_QUERY     = 8'h3F;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;

  // escape phase codes
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // path component dot tracking
  localparam logic [1:0] DOT_START = 2'd0;
  localparam logic [1:0] DOT_ONE   = 2'd1;
  localparam logic [1:0] DOT_TWO   = 2'd2;
  localparam logic [1:0] DOT_OTHER = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.ok     = 1'b1;
    r.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share the low three bits: 1..6
      r.nibble = {1'b1, c[2:0] + 3'd1};
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* src/url_path_percent_decoder.sv */
// URL path percent decoder with a path traversal check.
// Top level; uses urlpd_pkg for character codes and the hex decoder.
// One module, state update and result register only.

// Takes a request target one raw byte per transfer on the s_ side, s_tlast on
// the final byte, and returns exactly one result per input byte on the m_
// side: the decoded byte with a valid flag, and on the result for the last
// byte (m_tlast) the verdict, 1 when the path is safe. The target must begin
// with '/'; everything from the first '?' on is skipped; bad or truncated
// escapes, decoded control bytes or backslashes, and any ".." component
// reject it, after which no more bytes are emitted. One byte is taken every
// cycle: the per-byte state update sits between the input port and a single
// result register, and the input is held off only while that register is
// full and m_tready is low. Each result appears in the cycle after its byte.
// After the last byte the block is back in its start state for the next target.
module url_path_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] out_valid, [1] accepted
  output logic       m_tlast    // done_res
);

  logic       at_start, at_start_next;
  logic [1:0] escape_phase, escape_phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [1:0] dot_state, dot_state_next;
  logic       in_query, in_query_next;
  logic       failed, failed_next;

  logic          decoded;
  logic [7:0]    val;
  logic          res_valid;
  logic          res_acc;
  urlpd_pkg::hex_t hx;

  logic accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    at_start_next     = 1'b0;
    escape_phase_next = escape_phase;
    high_nibble_next  = high_nibble;
    dot_state_next    = dot_state;
    in_query_next     = in_query;
    failed_next       = failed;
    decoded           = 1'b0;
    val               = 8'd0;
    res_acc           = 1'b0;
    hx                = urlpd_pkg::hex_digit(s_tdata);

    if (!failed && !in_query) begin
      if (at_start && s_tdata != urlpd_pkg::CH_SLASH) begin
        failed_next = 1'b1;
      end else if (escape_phase == urlpd_pkg::ESC_NONE) begin
        if (s_tdata == urlpd_pkg::CH_QUERY) begin
          in_query_next = 1'b1;
        end else if (s_tdata == urlpd_pkg::CH_PERCENT) begin
          escape_phase_next = urlpd_pkg::ESC_HIGH;
        end else begin
          decoded = 1'b1;
          val     = s_tdata;
        end
      end else begin
        // '?' is not a hex digit, so a truncating '?' fails here too
        if (!hx.ok) begin
          failed_next = 1'b1;
        end else if (escape_phase == urlpd_pkg::ESC_HIGH) begin
          high_nibble_next  = hx.nibble;
          escape_phase_next = urlpd_pkg::ESC_LOW;
        end else begin
          val               = {high_nibble, hx.nibble};
          decoded           = 1'b1;
          escape_phase_next = urlpd_pkg::ESC_NONE;
        end
      end
    end

    if (decoded) begin
      // below 0x20 covers NUL
      if (val == urlpd_pkg::CH_BACKSLASH || val == urlpd_pkg::CH_NUL ||
          val < urlpd_pkg::CTRL_LIMIT) begin
        failed_next = 1'b1;
      end else if (val == urlpd_pkg::CH_SLASH) begin
        if (dot_state == urlpd_pkg::DOT_TWO) failed_next = 1'b1;
        dot_state_next = urlpd_pkg::DOT_START;
      end else if (val == urlpd_pkg::CH_DOT) begin
        if (dot_state == urlpd_pkg::DOT_START) dot_state_next = urlpd_pkg::DOT_ONE;
        else if (dot_state == urlpd_pkg::DOT_ONE) dot_state_next = urlpd_pkg::DOT_TWO;
        else dot_state_next = urlpd_pkg::DOT_OTHER;
      end else begin
        dot_state_next = urlpd_pkg::DOT_OTHER;
      end
    end

    if (s_tlast) begin
      if (escape_phase_next != urlpd_pkg::ESC_NONE) failed_next = 1'b1;
      if (dot_state_next == urlpd_pkg::DOT_TWO) failed_next = 1'b1;
      res_acc = !failed_next;
    end

    res_valid = decoded && !failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start     <= 1'b1;
      escape_phase <= urlpd_pkg::ESC_NONE;
      high_nibble  <= 4'd0;
      dot_state    <= urlpd_pkg::DOT_START;
      in_query     <= 1'b0;
      failed       <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        // end of target: back to start state
        at_start     <= 1'b1;
        escape_phase <= urlpd_pkg::ESC_NONE;
        high_nibble  <= 4'd0;
        dot_state    <= urlpd_pkg::DOT_START;
        in_query     <= 1'b0;
        failed       <= 1'b0;
      end else begin
        at_start     <= at_start_next;
        escape_phase <= escape_phase_next;
        high_nibble  <= high_nibble_next;
        dot_state    <= dot_state_next;
        in_query     <= in_query_next;
        failed       <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= res_valid ? val : 8'd0;
      m_tuser <= {res_acc, res_valid};
      m_tlast <= s_tlast;
    end
  end

endmodule

/* dv/url_path_percent_decoder_test.sv */
// Self-checking testbench for url_path_percent_decoder.
// Streams request targets byte by byte and checks every result against a
// scoreboard with its own decoder model; needs urlpd_pkg and the block.
module url_path_percent_decoder_test;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       ok;
  } path_result_t;

  class decode_scoreboard;
    // decoder state, mirrors the block
    logic       at_first;
    logic [1:0] esc_phase;
    logic [3:0] hi_nibble;
    logic [1:0] dots;
    logic       in_query;
    logic       rejected;

    path_result_t expected_q[$];
    int mismatches;
    int targets_seen;
    int targets_safe;
    int bytes_out;

    function new();
      mismatches   = 0;
      targets_seen = 0;
      targets_safe = 0;
      bytes_out    = 0;
      restart();
    endfunction

    function void restart();
      at_first  = 1'b1;
      esc_phase = urlpd_pkg::ESC_NONE;
      hi_nibble = 4'd0;
      dots      = urlpd_pkg::DOT_START;
      in_query  = 1'b0;
      rejected  = 1'b0;
    endfunction

    function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted input transfer -> one expected result
    function void note_input(logic [7:0] b, logic is_last);
      logic         decoded;
      logic [7:0]   val;
      int           h;
      path_result_t r;
      decoded = 1'b0;
      val     = 8'd0;
      if (!rejected && !in_query) begin
        if (at_first && b != urlpd_pkg::CH_SLASH) begin
          rejected = 1'b1;
        end else if (esc_phase == urlpd_pkg::ESC_NONE) begin
          if (b == urlpd_pkg::CH_QUERY) begin
            in_query = 1'b1;
          end else if (b == urlpd_pkg::CH_PERCENT) begin
            esc_phase = urlpd_pkg::ESC_HIGH;
          end else begin
            decoded = 1'b1;
            val     = b;
          end
        end else begin
          h = (b == urlpd_pkg::CH_QUERY) ? -1 : digit_value(b);
          if (h < 0) begin
            rejected = 1'b1;
          end else if (esc_phase == urlpd_pkg::ESC_HIGH) begin
            hi_nibble = 4'(h);
            esc_phase = urlpd_pkg::ESC_LOW;
          end else begin
            val       = {hi_nibble, 4'(h)};
            decoded   = 1'b1;
            esc_phase = urlpd_pkg::ESC_NONE;
          end
        end
      end
      at_first = 1'b0;

      if (decoded) begin
        if (val == urlpd_pkg::CH_BACKSLASH || val < urlpd_pkg::CTRL_LIMIT) begin
          rejected = 1'b1;
        end else if (val == urlpd_pkg::CH_SLASH) begin
          if (dots == urlpd_pkg::DOT_TWO) rejected = 1'b1;
          dots = urlpd_pkg::DOT_START;
        end else if (val == urlpd_pkg::CH_DOT) begin
          if (dots == urlpd_pkg::DOT_START) dots = urlpd_pkg::DOT_ONE;
          else if (dots == urlpd_pkg::DOT_ONE) dots = urlpd_pkg::DOT_TWO;
          else dots = urlpd_pkg::DOT_OTHER;
        end else begin
          dots = urlpd_pkg::DOT_OTHER;
        end
      end

      r.ok = 1'b0;
      if (is_last) begin
        if (esc_phase != urlpd_pkg::ESC_NONE) rejected = 1'b1;
        if (dots == urlpd_pkg::DOT_TWO) rejected = 1'b1;
        r.ok = !rejected;
      end
      r.valid = decoded && !rejected;
      r.data  = r.valid ? val : 8'd0;
      r.last  = is_last;
      expected_q.push_back(r);
      if (is_last) restart();
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] user, logic is_last);
      path_result_t e;
      path_result_t a;
      a.data  = data;
      a.valid = user[0];
      a.ok    = user[1];
      a.last  = is_last;
      if (a.last) begin
        targets_seen++;
        if (a.ok) targets_safe++;
      end
      if (a.valid) bytes_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: data=%02h valid=%0b last=%0b ok=%0b",
                   a.data, a.valid, a.last, a.ok);
        return;
      end
      e = expected_q.pop_front();
      if (a.data !== e.data || a.valid !== e.valid || a.last !== e.last || a.ok !== e.ok) begin
        mismatches++;
        // fields shown as data/valid/last/ok
        if (mismatches <= 10)
          $display("result error: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                   e.data, e.valid, e.last, e.ok, a.data, a.valid, a.last, a.ok);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  decode_scoreboard sb = new();
  logic [7:0] target_q[$];
  int src_idle  = 28;
  int sink_idle = 49;
  int bytes_in  = 0;

  url_path_percent_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("url_path_percent_decoder: mismatch");
    $finish;
  end

  // receiver side
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // s_tvalid stays high from one transfer into the next unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, is_last);
    bytes_in++;
  endtask

  task automatic send_target();
    foreach (target_q[i]) send_byte(target_q[i], i == target_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    target_q.delete();
    for (int i = 0; i < s.len(); i++) target_q.push_back(s[i]);
    send_target();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  // mostly well-formed paths with random content, some noise and broken ones
  task automatic make_target();
    int         n;
    int         pick;
    logic [7:0] v;
    target_q.delete();
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 10);
      repeat (n) target_q.push_back(8'($urandom));
      if ($urandom_range(0, 1)) target_q[0] = urlpd_pkg::CH_SLASH;
      return;
    end
    target_q.push_back(urlpd_pkg::CH_SLASH);
    n = $urandom_range(0, 12);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        target_q.push_back(urlpd_pkg::CH_DOT);
      end else if (pick < 38) begin
        target_q.push_back(urlpd_pkg::CH_SLASH);
      end else if (pick < 55) begin
        case ($urandom_range(0, 9))
          0: v = urlpd_pkg::CH_DOT;
          1: v = urlpd_pkg::CH_SLASH;
          2: v = urlpd_pkg::CH_BACKSLASH;
          3: v = 8'($urandom_range(0, 31));
          default: v = 8'($urandom_range(32, 255));
        endcase
        target_q.push_back(urlpd_pkg::CH_PERCENT);
        target_q.push_back(hex_char(v[7:4]));
        target_q.push_back(hex_char(v[3:0]));
      end else if (pick < 90) begin
        v = 8'($urandom_range(33, 126));
        if (v == urlpd_pkg::CH_PERCENT || v == urlpd_pkg::CH_QUERY ||
            v == urlpd_pkg::CH_BACKSLASH) v = "x";
        target_q.push_back(v);
      end else if (pick < 95) begin
        // query tail: anything goes after '?'
        target_q.push_back(urlpd_pkg::CH_QUERY);
        repeat ($urandom_range(0, 5)) target_q.push_back(8'($urandom));
        return;
      end else begin
        target_q.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 99) < 5) begin
      target_q.push_back(urlpd_pkg::CH_PERCENT);
      if ($urandom_range(0, 1)) target_q.push_back(hex_char(4'($urandom)));
      if ($urandom_range(0, 1)) target_q.push_back(urlpd_pkg::CH_QUERY);
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'd0;
    s_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed targets
    send_text("/");
    send_text("a");
    send_text("?");
    send_text("%");
    send_text("/%4");
    send_text("/%?");
    send_text("/%g");
    send_text("/%5C");
    send_text("/..");
    send_text("/../");
    target_q.delete();
    target_q.push_back(urlpd_pkg::CH_SLASH);
    target_q.push_back(8'hFF);
    target_q.push_back(urlpd_pkg::CH_NUL);
    send_target();

    // random targets in three pacing phases
    for (int p = 0; p < 3; p++) begin
      if (p == 0) begin
        src_idle  = 28;
        sink_idle = 49;
      end else if (p == 1) begin
        src_idle  = 49;
        sink_idle = 28;
      end else begin
        src_idle  = 0;
        sink_idle = 0;
      end
      while (bytes_in < 27 + (p + 1) * 417) begin
        make_target();
        send_target();
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.mismatches++;

    $display("sent %0d bytes in %0d targets, %0d judged safe, %0d path bytes emitted",
             bytes_in, sb.targets_seen, sb.targets_safe, sb.bytes_out);
    $display("pacing: sender/receiver gaps 28/49, 49/28, then none; %0d errors",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("url_path_percent_decoder: match");
    end else begin
      $display("url_path_percent_decoder: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/urlpd_pkg.sv
src/url_path_percent_decoder.sv
dv/url_path_percent_decoder_test.sv
